/* rtl/mips_subset_instruction_executor_assert.svh */
// assertion macros shared by the executor rtl
`ifndef MIPS_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define MIPS_SUBSET_INSTRUCTION_EXECUTOR_ASSERT_SVH
`ifndef ASSERT_OFF
// checked property, ignored while reset is asserted
`define MSIE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also checked during reset
`define MSIE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MSIE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSIE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* rtl/msie_pkg.sv */
// shared types and constants of the mips subset executor
`timescale 1ns / 1ps
`default_nettype none
package msie_pkg;

	localparam int unsigned XLEN          = 32;
	localparam int unsigned REG_IDX_W     = 4;
	localparam int unsigned NUM_GPR       = 13;
	localparam int unsigned MEM_WORDS_DEF = 256;
	localparam int unsigned DIV_STEPS     = XLEN;

	localparam logic [REG_IDX_W-1:0] IDX_ZERO = 4'd0;
	localparam logic [REG_IDX_W-1:0] IDX_LO   = 4'd9;
	localparam logic [REG_IDX_W-1:0] IDX_RA   = 4'd11;
	localparam logic [REG_IDX_W-1:0] IDX_PC   = 4'd13;

	localparam logic [XLEN-1:0] RA_RESET = 32'hFFFF_FFFF;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MULT  = 4'd2,
		OP_DIV   = 4'd3,
		OP_MFLO  = 4'd4,
		OP_OR    = 4'd5,
		OP_AND   = 4'd6,
		OP_XOR   = 4'd7,
		OP_JUMP  = 4'd8,
		OP_JAL   = 4'd9,
		OP_BEQ   = 4'd10,
		OP_STORE = 4'd11,
		OP_LOAD  = 4'd12
	} op_t;

	typedef struct packed {
		logic [3:0]           req_type;
		logic [REG_IDX_W-1:0] reg_a;
		logic [REG_IDX_W-1:0] reg_b;
		logic [REG_IDX_W-1:0] reg_c;
		logic                 use_imm;
		logic signed [31:0]   imm_value;
	} req_t;

	typedef struct packed {
		logic [31:0]          next_pc;
		logic                 wr_en;
		logic [REG_IDX_W-1:0] wr_reg;
		logic [31:0]          wr_value;
		logic                 fault;
	} rsp_t;

	typedef enum logic [1:0] {
		SEL_A,
		SEL_B,
		SEL_C,
		SEL_LO
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RD_A,
		ST_RD_B,
		ST_RD_C,
		ST_RD_LO,
		ST_RD_WAIT,
		ST_EXEC,
		ST_DIV_RUN,
		ST_MEM,
		ST_FINISH
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic    clear;
		logic    load_req;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    exec;
		logic    div_start;
		logic    mem_wr;
		logic    commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [3:0] op;
		logic       clear_last;
		logic       div_done;
	} sts_t;

endpackage
`default_nettype wire

/* rtl/msie_ram.sv */
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module msie_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/msie_div.sv */
// iterative restoring unsigned divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module msie_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [msie_pkg::XLEN-1:0] dividend,
	input  logic [msie_pkg::XLEN-1:0] divisor,
	output logic                     done,
	output logic [msie_pkg::XLEN-1:0] quot
);

	localparam int unsigned CNT_W = $clog2(msie_pkg::DIV_STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(msie_pkg::DIV_STEPS - 1);

	logic                      busy_q;
	logic                      done_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [msie_pkg::XLEN-1:0] divisor_q;
	logic [msie_pkg::XLEN-1:0] quot_q;
	logic [msie_pkg::XLEN-1:0] rem_q;
	logic [msie_pkg::XLEN:0]   shifted;
	logic [msie_pkg::XLEN+1:0] diff;
	logic                      qbit;
	logic [msie_pkg::XLEN-1:0] rem_next;

	// zero divisor never borrows, so the quotient fills with ones
	always_comb begin
		shifted  = {rem_q, quot_q[msie_pkg::XLEN-1]};
		diff     = {1'b0, shifted} - {2'b00, divisor_q};
		qbit     = ~diff[msie_pkg::XLEN+1];
		rem_next = qbit ? diff[msie_pkg::XLEN-1:0] : shifted[msie_pkg::XLEN-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			quot_q    <= dividend;
			rem_q     <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[msie_pkg::XLEN-2:0], qbit};
			rem_q  <= rem_next;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

/* rtl/msie_dpath.sv */
// datapath: register file, pc, operand registers, alu, divider, data memory
`timescale 1ns / 1ps
`default_nettype none
module msie_dpath #(
	parameter int unsigned MEM_WORDS = msie_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  msie_pkg::cmd_t cmd,
	output msie_pkg::sts_t sts,
	input  msie_pkg::req_t req,
	output msie_pkg::rsp_t rsp
);

	localparam int unsigned MEM_AW = $clog2(MEM_WORDS);
	localparam int unsigned RF_AW  = $clog2(msie_pkg::NUM_GPR);
	localparam int unsigned XLEN   = msie_pkg::XLEN;

	msie_pkg::req_t              req_q;
	msie_pkg::rsp_t              rsp_q;
	msie_pkg::rsp_t              fin;
	logic [XLEN-1:0]             pc_q;
	logic [XLEN-1:0]             aval_q;
	logic [XLEN-1:0]             bval_q;
	logic [XLEN-1:0]             creg_q;
	logic [XLEN-1:0]             lo_q;
	logic [XLEN-1:0]             res_v_q;
	logic [msie_pkg::NUM_GPR-1:0] rf_valid_q;
	logic [MEM_AW-1:0]           clr_cnt_q;

	logic                        rd_en_s1;
	msie_pkg::rd_sel_t           rd_sel_s1;
	logic [msie_pkg::REG_IDX_W-1:0] rd_idx_s1;
	logic                        rd_valid_s1;

	logic [msie_pkg::REG_IDX_W-1:0] rd_idx;
	logic [RF_AW-1:0]            rf_raddr;
	logic [XLEN-1:0]             rf_rdata;
	logic [XLEN-1:0]             rd_data;
	logic                        rf_we;

	logic [XLEN-1:0]             cval;
	logic [XLEN-1:0]             alu_v;
	logic [XLEN-1:0]             pc_inc;
	logic [XLEN-1:0]             addr_sum;
	logic [XLEN-1:0]             div_dividend;
	logic [XLEN-1:0]             div_divisor;
	logic                        div_done;
	logic [XLEN-1:0]             div_quot;
	logic [MEM_AW-1:0]           mem_addr;
	logic                        dmem_we;
	logic [MEM_AW-1:0]           dmem_waddr;
	logic [XLEN-1:0]             dmem_wdata;
	logic [XLEN-1:0]             dmem_rdata;

	logic [msie_pkg::REG_IDX_W-1:0] dest;
	logic [XLEN-1:0]             fin_v;
	logic                        do_wr;

	// register file read port
	always_comb begin
		case (cmd.rd_sel)
			msie_pkg::SEL_A:  rd_idx = req_q.reg_a;
			msie_pkg::SEL_B:  rd_idx = req_q.reg_b;
			msie_pkg::SEL_C:  rd_idx = req_q.reg_c;
			msie_pkg::SEL_LO: rd_idx = msie_pkg::IDX_LO;
			default:          rd_idx = msie_pkg::IDX_ZERO;
		endcase
		rf_raddr = (rd_idx < 4'(msie_pkg::NUM_GPR)) ? rd_idx[RF_AW-1:0] : '0;
	end

	// zero, pc and unused indexes never come from the ram
	always_comb begin
		if (rd_idx_s1 == msie_pkg::IDX_PC) begin
			rd_data = pc_q;
		end else if (rd_idx_s1 == msie_pkg::IDX_ZERO || rd_idx_s1 > msie_pkg::IDX_PC) begin
			rd_data = '0;
		end else if (!rd_valid_s1) begin
			rd_data = (rd_idx_s1 == msie_pkg::IDX_RA) ? msie_pkg::RA_RESET : '0;
		end else begin
			rd_data = rf_rdata;
		end
	end

	msie_ram #(
		.WIDTH (XLEN),
		.DEPTH (msie_pkg::NUM_GPR)
	) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (fin.wr_reg[RF_AW-1:0]),
		.wdata (fin.wr_value),
		.raddr (rf_raddr),
		.rdata (rf_rdata)
	);

	// alu and multiplier, registered before write-back
	always_comb begin
		cval   = req_q.use_imm ? req_q.imm_value : creg_q;
		pc_inc = pc_q + 32'd1;
		case (msie_pkg::op_t'(req_q.req_type))
			msie_pkg::OP_ADD:  alu_v = bval_q + cval;
			msie_pkg::OP_SUB:  alu_v = bval_q - cval;
			msie_pkg::OP_MULT: alu_v = bval_q * cval;
			msie_pkg::OP_OR:   alu_v = bval_q | cval;
			msie_pkg::OP_AND:  alu_v = bval_q & cval;
			msie_pkg::OP_XOR:  alu_v = bval_q ^ cval;
			default:           alu_v = '0;
		endcase
	end

	// word address wraps at the memory size, a power of two, so only low bits count
	always_comb begin
		addr_sum     = creg_q + req_q.imm_value;
		div_dividend = bval_q;
		div_divisor  = cval;
	end

	msie_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot)
	);

	assign mem_addr = addr_sum[MEM_AW-1:0];

	always_comb begin
		dmem_we    = cmd.clear | cmd.mem_wr;
		dmem_waddr = cmd.clear ? clr_cnt_q : mem_addr;
		dmem_wdata = cmd.clear ? '0 : aval_q;
	end

	msie_ram #(
		.WIDTH (XLEN),
		.DEPTH (MEM_WORDS)
	) u_dmem (
		.clk   (clk),
		.we    (dmem_we),
		.waddr (dmem_waddr),
		.wdata (dmem_wdata),
		.raddr (mem_addr),
		.rdata (dmem_rdata)
	);

	// write-back and next pc
	always_comb begin
		fin         = '0;
		fin.next_pc = pc_inc;
		dest        = req_q.reg_a;
		fin_v       = res_v_q;
		do_wr       = 1'b0;
		case (msie_pkg::op_t'(req_q.req_type))
			msie_pkg::OP_ADD, msie_pkg::OP_SUB, msie_pkg::OP_OR,
			msie_pkg::OP_AND, msie_pkg::OP_XOR: begin
				do_wr = 1'b1;
			end
			msie_pkg::OP_MULT: begin
				dest  = msie_pkg::IDX_LO;
				do_wr = 1'b1;
			end
			msie_pkg::OP_DIV: begin
				fin_v = div_quot;
				dest  = msie_pkg::IDX_LO;
				do_wr = 1'b1;
			end
			msie_pkg::OP_MFLO: begin
				fin_v = lo_q;
				do_wr = 1'b1;
			end
			msie_pkg::OP_JUMP: begin
				fin.next_pc = req_q.use_imm ? req_q.imm_value : aval_q;
			end
			msie_pkg::OP_JAL: begin
				fin.wr_en    = 1'b1;
				fin.wr_reg   = msie_pkg::IDX_RA;
				fin.wr_value = pc_inc;
				// target through ra sees the link value just written
				if (req_q.use_imm) begin
					fin.next_pc = req_q.imm_value;
				end else if (req_q.reg_a == msie_pkg::IDX_RA) begin
					fin.next_pc = pc_inc;
				end else begin
					fin.next_pc = aval_q;
				end
			end
			msie_pkg::OP_BEQ: begin
				fin.next_pc = (aval_q == bval_q) ? (pc_q + cval) : pc_inc;
			end
			msie_pkg::OP_STORE: begin
				fin.next_pc = pc_inc;
			end
			msie_pkg::OP_LOAD: begin
				fin_v = dmem_rdata;
				do_wr = 1'b1;
			end
			default: begin
				fin.fault   = 1'b1;
				fin.next_pc = pc_q;
			end
		endcase
		if (do_wr) begin
			if (dest inside {[4'd1 : msie_pkg::IDX_PC - 4'd1]}) begin
				fin.wr_en    = 1'b1;
				fin.wr_reg   = dest;
				fin.wr_value = fin_v;
			end else if (dest == msie_pkg::IDX_PC) begin
				fin.wr_en    = 1'b1;
				fin.wr_reg   = dest;
				fin.wr_value = fin_v;
				fin.next_pc  = fin_v + 32'd1;
			end
		end
		rf_we = cmd.commit && fin.wr_en && (fin.wr_reg != msie_pkg::IDX_PC);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q       <= '0;
			rf_valid_q <= '0;
			clr_cnt_q  <= '0;
			rd_en_s1   <= 1'b0;
		end else begin
			rd_en_s1 <= cmd.rd_en;
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
			end
			if (cmd.commit) begin
				pc_q <= fin.next_pc;
			end
			if (rf_we) begin
				rf_valid_q[fin.wr_reg[RF_AW-1:0]] <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req;
		end
		rd_sel_s1   <= cmd.rd_sel;
		rd_idx_s1   <= rd_idx;
		rd_valid_s1 <= rf_valid_q[rf_raddr];
		if (rd_en_s1) begin
			case (rd_sel_s1)
				msie_pkg::SEL_A:  aval_q <= rd_data;
				msie_pkg::SEL_B:  bval_q <= rd_data;
				msie_pkg::SEL_C:  creg_q <= rd_data;
				msie_pkg::SEL_LO: lo_q   <= rd_data;
				default:          lo_q   <= rd_data;
			endcase
		end
		if (cmd.exec) begin
			res_v_q <= alu_v;
		end
		if (cmd.commit) begin
			rsp_q <= fin;
		end
	end

	always_comb begin
		sts.op         = req_q.req_type;
		sts.clear_last = (clr_cnt_q == MEM_AW'(MEM_WORDS - 1));
		sts.div_done   = div_done;
	end

	assign rsp = rsp_q;

endmodule
`default_nettype wire

/* rtl/msie_ctrl.sv */
// controller: sequences operand reads, execute, divide, memory and commit
`timescale 1ns / 1ps
`include "mips_subset_instruction_executor_assert.svh"
`default_nettype none
module msie_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output msie_pkg::cmd_t cmd,
	input  msie_pkg::sts_t sts
);

	msie_pkg::state_t state_q;
	msie_pkg::state_t state_d;
	logic             rsp_valid_q;
	logic             slot_free;
	logic             needs_div;
	logic             needs_mem;

	always_comb begin
		slot_free = !rsp_valid_q || !rsp_stall;
		needs_mem = sts.op inside {msie_pkg::OP_STORE, msie_pkg::OP_LOAD};
		needs_div = (sts.op == msie_pkg::OP_DIV);
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			msie_pkg::ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) begin
					state_d = msie_pkg::ST_IDLE;
				end
			end
			msie_pkg::ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = msie_pkg::ST_RD_A;
				end
			end
			msie_pkg::ST_RD_A: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = msie_pkg::SEL_A;
				state_d    = msie_pkg::ST_RD_B;
			end
			msie_pkg::ST_RD_B: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = msie_pkg::SEL_B;
				state_d    = msie_pkg::ST_RD_C;
			end
			msie_pkg::ST_RD_C: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = msie_pkg::SEL_C;
				state_d    = msie_pkg::ST_RD_LO;
			end
			msie_pkg::ST_RD_LO: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = msie_pkg::SEL_LO;
				state_d    = msie_pkg::ST_RD_WAIT;
			end
			msie_pkg::ST_RD_WAIT: begin
				state_d = msie_pkg::ST_EXEC;
			end
			msie_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				if (needs_div) begin
					cmd.div_start = 1'b1;
					state_d       = msie_pkg::ST_DIV_RUN;
				end else if (needs_mem) begin
					state_d = msie_pkg::ST_MEM;
				end else begin
					state_d = msie_pkg::ST_FINISH;
				end
			end
			msie_pkg::ST_DIV_RUN: begin
				if (sts.div_done) begin
					state_d = msie_pkg::ST_FINISH;
				end
			end
			msie_pkg::ST_MEM: begin
				// store writes here, load read data is already registered
				cmd.mem_wr = (sts.op == msie_pkg::OP_STORE);
				state_d    = msie_pkg::ST_FINISH;
			end
			msie_pkg::ST_FINISH: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = msie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = msie_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= msie_pkg::ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != msie_pkg::ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	`MSIE_ASSERT(a_accept_starts_reads, clk, arst_n, req_valid && !req_stall |=> state_q == msie_pkg::ST_RD_A, "accepted request did not start operand reads")
	`MSIE_ASSERT(a_div_done_in_run, clk, arst_n, sts.div_done |-> state_q == msie_pkg::ST_DIV_RUN, "divider finished outside divide state")
	`MSIE_ASSERT(a_commit_shows_rsp, clk, arst_n, cmd.commit |=> rsp_valid, "commit did not raise response valid")
	`MSIE_ASSERT_ALWAYS(a_no_rsp_while_clear, clk, state_q == msie_pkg::ST_CLEAR |-> !rsp_valid_q, "response valid during memory clear")

endmodule
`default_nettype wire

/* rtl/mips_subset_instruction_executor.sv */
// top level of the mips subset instruction executor
//
// channel   dir  handshake               payload
// request   in   req_valid / req_stall   req (msie_pkg::req_t, one decoded instruction)
// response  out  rsp_valid / rsp_stall   rsp (msie_pkg::rsp_t, next pc and write-back)
//
// each request, acceptance to acceptance, steps through idle, four register file reads,
// wait, execute and commit; div adds a run state for the bit-serial divider
// store and load add a data memory state; the word address is base plus offset
// wrapped at MEM_WORDS, which is a power of two
// after reset the data memory is cleared one word a cycle
// a stalled response holds in the output register; the next request waits before commit until it is taken
`timescale 1ns / 1ps
`default_nettype none
module mips_subset_instruction_executor #(
	parameter int unsigned MEM_WORDS = msie_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	// request channel
	input  logic           req_valid,
	output logic           req_stall,
	input  msie_pkg::req_t req,
	// response channel
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output msie_pkg::rsp_t rsp
);

	// command and status between controller and datapath
	msie_pkg::cmd_t cmd;
	msie_pkg::sts_t sts;

	// sequencing and handshakes
	msie_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// register file, pc, alu, divider and data memory
	msie_dpath #(
		.MEM_WORDS (MEM_WORDS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
`default_nettype wire
